@@ hdl/two_set_store_set_algebra_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-set store
// Clocked concurrent assertion forms shared by the set store RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_SET_STORE_SET_ALGEBRA_UNIT_MACROS_SVH
`define TWO_SET_STORE_SET_ALGEBRA_UNIT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TSA_ASSERT_NEXT(label, cond, rhs, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (rhs)) \
        else $error(msg);

`endif

@@ hdl/tsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-set store package
// Item types, operation codes and result kinds shared by the set store.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int unsigned FIELD_BITS = 16;

    typedef enum logic [2:0] {
        OP_INS_A     = 3'd0,
        OP_INS_B     = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_UNION     = 3'd3,
        OP_INTERSECT = 3'd4,
        OP_A_MINUS_B = 3'd5,
        OP_B_MINUS_A = 3'd6,
        OP_SUBSET    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        K_ELEMENT   = 3'd0,
        K_INSERTED  = 3'd1,
        K_DUPLICATE = 3'd2,
        K_FULL      = 3'd3,
        K_EMPTY     = 3'd4,
        K_SUB_YES   = 3'd5,
        K_SUB_NO    = 3'd6
    } t_kind;

    typedef struct packed {
        t_op                           operation;
        logic signed [FIELD_BITS-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0]  element;
        t_kind                         kind;
        logic                          last;
    } t_out_item;

endpackage

@@ hdl/tsa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/two_set_store_set_algebra_unit.sv @@
// Operation: an insert scans its target set for a duplicate before it writes; a query
// compares each element of one store against the elements of the other,
// and a union adds a pass over A.
// Throughput: one item at a time; the stall is held until the final result is registered.
// The scans are serialised by the single shared equality compare and the one read port per store.
// Reset (synchronous, active low) empties both sets; store contents are left unset.
// ----------------------------------------------------------------------------
// Two-set store with set algebra
// Keeps sets A and B in two RAMs and answers inserts, union, intersection,
// differences and subset queries by scanning the stores with one comparator.
// ----------------------------------------------------------------------------
`include "two_set_store_set_algebra_unit_macros.svh"

module two_set_store_set_algebra_unit
    import tsa_pkg::*;
#(
    parameter int unsigned SET_DEPTH   = 16,
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item
);

    localparam int unsigned AW = $clog2(SET_DEPTH);
    localparam int unsigned CW = $clog2(SET_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUT_RD,
        S_OUT_LAT,
        S_IN_RD,
        S_IN_CMP,
        S_DECIDE,
        S_EMIT,
        S_INS_END,
        S_FINISH
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_outer_b, n_outer_b;
    logic                   r_union_a, n_union_a;
    logic                   r_keep_in, n_keep_in;
    logic                   r_is_ins, n_is_ins;
    logic                   r_is_sub, n_is_sub;
    logic                   r_sub_ok, n_sub_ok;
    logic                   r_found, n_found;
    logic                   r_have, n_have;
    logic [CW-1:0]          r_i, n_i;
    logic [CW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_count_a, n_count_a;
    logic [CW-1:0]          r_count_b, n_count_b;
    logic [VALUE_WIDTH-1:0] r_cand, n_cand;
    logic [VALUE_WIDTH-1:0] r_held, n_held;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_item, n_out_item;

    logic                   w_we;
    logic                   w_out_free;
    logic [CW-1:0]          w_sc;
    logic [CW-1:0]          w_tc;
    logic [AW-1:0]          w_raddr_a;
    logic [AW-1:0]          w_raddr_b;
    logic [VALUE_WIDTH-1:0] w_rdata_a;
    logic [VALUE_WIDTH-1:0] w_rdata_b;
    logic [VALUE_WIDTH-1:0] w_outer_data;
    logic [VALUE_WIDTH-1:0] w_inner_data;

    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_sc         = r_outer_b ? r_count_b : r_count_a;
    assign w_tc         = r_outer_b ? r_count_a : r_count_b;
    assign w_raddr_a    = r_outer_b ? r_j[AW-1:0] : r_i[AW-1:0];
    assign w_raddr_b    = r_outer_b ? r_i[AW-1:0] : r_j[AW-1:0];
    assign w_outer_data = r_outer_b ? w_rdata_b : w_rdata_a;
    assign w_inner_data = r_outer_b ? w_rdata_a : w_rdata_b;

    tsa_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SET_DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we && r_outer_b),
        .i_waddr (w_tc[AW-1:0]),
        .i_wdata (r_cand),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    tsa_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SET_DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we && !r_outer_b),
        .i_waddr (w_tc[AW-1:0]),
        .i_wdata (r_cand),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    always_comb begin
        n_state     = r_state;
        n_outer_b   = r_outer_b;
        n_union_a   = r_union_a;
        n_keep_in   = r_keep_in;
        n_is_ins    = r_is_ins;
        n_is_sub    = r_is_sub;
        n_sub_ok    = r_sub_ok;
        n_found     = r_found;
        n_have      = r_have;
        n_i         = r_i;
        n_j         = r_j;
        n_count_a   = r_count_a;
        n_count_b   = r_count_b;
        n_cand      = r_cand;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        w_we        = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cand    = VALUE_WIDTH'($unsigned(i_in_item.value));
                    n_i       = '0;
                    n_j       = '0;
                    n_found   = 1'b0;
                    n_have    = 1'b0;
                    n_sub_ok  = 1'b1;
                    n_is_ins  = 1'b0;
                    n_is_sub  = 1'b0;
                    n_union_a = 1'b0;
                    n_keep_in = 1'b0;
                    n_outer_b = 1'b0;
                    unique case (i_in_item.operation)
                        OP_INS_A: begin
                            n_is_ins  = 1'b1;
                            n_outer_b = 1'b1;
                            n_state   = S_IN_RD;
                        end
                        OP_INS_B: begin
                            n_is_ins = 1'b1;
                            n_state  = S_IN_RD;
                        end
                        OP_CLEAR: begin
                            n_count_a = '0;
                            n_count_b = '0;
                        end
                        OP_UNION: begin
                            n_union_a = 1'b1;
                            n_state   = S_OUT_RD;
                        end
                        OP_INTERSECT: begin
                            n_keep_in = 1'b1;
                            n_state   = S_OUT_RD;
                        end
                        OP_A_MINUS_B: begin
                            n_state = S_OUT_RD;
                        end
                        OP_B_MINUS_A: begin
                            n_outer_b = 1'b1;
                            n_state   = S_OUT_RD;
                        end
                        OP_SUBSET: begin
                            n_is_sub = 1'b1;
                            n_state  = S_OUT_RD;
                        end
                    endcase
                end
            end
            S_OUT_RD: begin
                if (r_i >= w_sc) begin
                    if (r_union_a) begin
                        n_union_a = 1'b0;
                        n_outer_b = 1'b1;
                        n_i       = '0;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_OUT_LAT;
                end
            end
            S_OUT_LAT: begin
                n_cand = w_outer_data;
                if (r_union_a) begin
                    n_state = S_EMIT;
                end else begin
                    n_j     = '0;
                    n_found = 1'b0;
                    n_state = S_IN_RD;
                end
            end
            S_IN_RD: begin
                if (r_j >= w_tc) begin
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_IN_CMP;
                end
            end
            S_IN_CMP: begin
                if (w_inner_data == r_cand) begin
                    n_found = 1'b1;
                    n_state = S_DECIDE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_IN_RD;
                end
            end
            S_DECIDE: begin
                if (r_is_ins) begin
                    n_state = S_INS_END;
                end else if (r_found == r_keep_in) begin
                    if (r_is_sub) begin
                        n_sub_ok = 1'b0;
                        n_i      = r_i + 1'b1;
                        n_state  = S_OUT_RD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            S_EMIT: begin
                if (!r_have) begin
                    n_have  = 1'b1;
                    n_held  = r_cand;
                    n_i     = r_i + 1'b1;
                    n_state = S_OUT_RD;
                end else if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_item.element = FIELD_BITS'(r_held);
                    n_out_item.kind    = K_ELEMENT;
                    n_out_item.last    = 1'b0;
                    n_held             = r_cand;
                    n_i                = r_i + 1'b1;
                    n_state            = S_OUT_RD;
                end
            end
            S_INS_END: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out_item.element = '0;
                    n_out_item.last    = 1'b1;
                    if (r_found) begin
                        n_out_item.kind = K_DUPLICATE;
                    end else if (w_tc >= CW'(SET_DEPTH)) begin
                        n_out_item.kind = K_FULL;
                    end else begin
                        n_out_item.kind = K_INSERTED;
                        w_we            = 1'b1;
                        if (r_outer_b) begin
                            n_count_a = r_count_a + 1'b1;
                        end else begin
                            n_count_b = r_count_b + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_item.last = 1'b1;
                    if (r_is_sub) begin
                        n_out_item.element = '0;
                        n_out_item.kind    = r_sub_ok ? K_SUB_YES : K_SUB_NO;
                    end else if (r_have) begin
                        n_out_item.element = FIELD_BITS'(r_held);
                        n_out_item.kind    = K_ELEMENT;
                    end else begin
                        n_out_item.element = '0;
                        n_out_item.kind    = K_EMPTY;
                    end
                    n_have  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_outer_b  <= n_outer_b;
        r_union_a  <= n_union_a;
        r_keep_in  <= n_keep_in;
        r_is_ins   <= n_is_ins;
        r_is_sub   <= n_is_sub;
        r_sub_ok   <= n_sub_ok;
        r_found    <= n_found;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cand     <= n_cand;
        r_held     <= n_held;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have      <= 1'b0;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_count_a   <= n_count_a;
            r_count_b   <= n_count_b;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `TSA_ASSERT(a_count_bound, (r_count_a <= CW'(SET_DEPTH)) && (r_count_b <= CW'(SET_DEPTH)), "set count exceeds depth")
    `TSA_ASSERT(a_marker_zero, (r_out_valid && (r_out_item.kind != K_ELEMENT)) |-> (r_out_item.element == '0), "non-element result carries a value")
    `TSA_ASSERT(a_idle_no_held, (r_state == S_IDLE) |-> !r_have, "held result left behind in idle")
    `TSA_ASSERT_NEXT(a_insert_grows, w_we && r_outer_b, r_count_a == $past(r_count_a) + 1'b1, "insert into A did not grow the count")

endmodule

@@ tb/two_set_store_set_algebra_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the two-set store with set algebra
// Drives inserts, clears and set queries through the valid/stall handshake,
// predicts every result item from a private copy of both sets and checks the
// block's results against it in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module two_set_store_set_algebra_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsa_pkg::*;

    localparam int unsigned DEPTH         = 16;
    localparam int unsigned RANDOM_ITEMS  = 80;
    localparam int unsigned SETTLE_CYCLES = 600;
    localparam int unsigned MAX_REPORTS   = 10;

    class set_algebra_scoreboard;
        logic [FIELD_BITS-1:0] members [2][DEPTH];
        int unsigned           size [2];
        t_out_item             awaited [$];
        int unsigned           faults;

        function new();
            size[0] = 0;
            size[1] = 0;
            faults  = 0;
        endfunction

        function bit holds(int unsigned s, logic [FIELD_BITS-1:0] v);
            for (int unsigned i = 0; i < size[s]; i++) begin
                if (members[s][i] == v) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void push_single(t_kind k);
            awaited.push_back('{element: '0, kind: k, last: 1'b1});
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_input(t_in_item it);
            logic [FIELD_BITS-1:0] found [$];
            int unsigned           s;
            int unsigned           src;
            int unsigned           other;
            bit                    keep;
            bit                    subset;
            t_out_item             res;
            subset = 1'b1;
            s      = (it.operation == OP_INS_B) ? 1 : 0;
            case (it.operation)
                OP_INS_A, OP_INS_B: begin
                    if (holds(s, it.value)) begin
                        push_single(K_DUPLICATE);
                    end else if (size[s] >= DEPTH) begin
                        push_single(K_FULL);
                    end else begin
                        members[s][size[s]] = it.value;
                        size[s]++;
                        push_single(K_INSERTED);
                    end
                end
                OP_CLEAR: begin
                    size[0] = 0;
                    size[1] = 0;
                end
                OP_SUBSET: begin
                    for (int unsigned i = 0; i < size[0]; i++) begin
                        if (!holds(1, members[0][i])) begin
                            subset = 1'b0;
                        end
                    end
                    push_single(subset ? K_SUB_YES : K_SUB_NO);
                end
                default: begin
                    if (it.operation == OP_UNION) begin
                        for (int unsigned i = 0; i < size[0]; i++) begin
                            found.push_back(members[0][i]);
                        end
                    end
                    src   = (it.operation == OP_INTERSECT || it.operation == OP_A_MINUS_B) ? 0 : 1;
                    other = 1 - src;
                    keep  = (it.operation == OP_INTERSECT);
                    for (int unsigned i = 0; i < size[src]; i++) begin
                        if (holds(other, members[src][i]) == keep) begin
                            found.push_back(members[src][i]);
                        end
                    end
                    if (found.size() == 0) begin
                        push_single(K_EMPTY);
                    end else begin
                        for (int unsigned i = 0; i < found.size(); i++) begin
                            res.element = found[i];
                            res.kind    = K_ELEMENT;
                            res.last    = (i == found.size() - 1);
                            awaited.push_back(res);
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (awaited.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("%0t: result item with none awaited: element %0d kind %0d last %0b",
                             $realtime, got.element, got.kind, got.last);
                end
                return;
            end
            want = awaited.pop_front();
            if (got.element !== want.element || got.kind !== want.kind ||
                got.last !== want.last) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("%0t: mismatch: expected element %0d kind %0d last %0b, got element %0d kind %0d last %0b",
                             $realtime, want.element, want.kind, want.last,
                             got.element, got.kind, got.last);
                end
            end
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    set_algebra_scoreboard sb;
    bit                    calm       = 1'b0;
    int unsigned           items_sent = 0;

    two_set_store_set_algebra_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_item);
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end

    task automatic send(input t_op op, input logic [FIELD_BITS-1:0] v);
        t_in_item it;
        it.operation = op;
        it.value     = v;
        while (!calm && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_input(it);
        items_sent++;
    endtask

    initial begin : stimulus
        logic [FIELD_BITS-1:0] pool [24];
        int unsigned           pool_size;
        int unsigned           n;
        int unsigned           seq;
        int unsigned           base;
        int unsigned           heavy;
        int unsigned           tgt;
        int unsigned           idx;
        int unsigned           start [2];
        int unsigned           next [2];
        bit                    big;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Queries on two empty sets, then the value extremes and duplicates.
        send(OP_UNION, 16'h0000);
        send(OP_INTERSECT, 16'hffff);
        send(OP_A_MINUS_B, 16'h0000);
        send(OP_B_MINUS_A, 16'hffff);
        send(OP_SUBSET, 16'h0000);
        send(OP_INS_A, 16'h8000);
        send(OP_INS_A, 16'h7fff);
        send(OP_INS_A, 16'h0000);
        send(OP_INS_A, 16'hffff);
        send(OP_INS_A, 16'h7fff);
        send(OP_INS_B, 16'hffff);
        send(OP_INS_B, 16'h1234);
        send(OP_INS_B, 16'h8000);
        send(OP_INS_B, 16'h8000);
        send(OP_UNION, 16'h0000);
        send(OP_INTERSECT, 16'h0000);
        send(OP_A_MINUS_B, 16'h0000);
        send(OP_B_MINUS_A, 16'h0000);
        send(OP_SUBSET, 16'h0000);
        send(OP_CLEAR, 16'h5a5a);
        send(OP_INS_B, 16'h00ff);
        send(OP_SUBSET, 16'hffff);
        send(OP_B_MINUS_A, 16'h0000);
        send(OP_INTERSECT, 16'h0000);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end

        base = items_sent;
        seq  = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            calm = (seq == 1);
            if ($urandom_range(0, 9) < 8) begin
                send(OP_CLEAR, 16'($urandom));
                big       = ($urandom_range(0, 3) == 0);
                pool_size = big ? $urandom_range(18, 24) : $urandom_range(3, 12);
                n         = big ? $urandom_range(34, 40) : $urandom_range(0, 10);
                for (int unsigned i = 0; i < pool_size; i++) begin
                    pool[i] = 16'($urandom);
                end
                heavy    = $urandom_range(0, 1);
                start[0] = 0;
                start[1] = $urandom_range(0, pool_size - 1);
                next[0]  = 0;
                next[1]  = 0;
                for (int unsigned k = 0; k < n; k++) begin
                    tgt = ($urandom_range(0, 3) == 0) ? 1 - heavy : heavy;
                    if ($urandom_range(0, 4) == 0) begin
                        idx = $urandom_range(0, pool_size - 1);
                    end else begin
                        idx = (start[tgt] + next[tgt]) % pool_size;
                        next[tgt]++;
                    end
                    send(tgt ? OP_INS_B : OP_INS_A, pool[idx]);
                end
                repeat ($urandom_range(3, 7)) begin
                    send(t_op'($urandom_range(OP_UNION, OP_SUBSET)), 16'($urandom));
                end
            end else begin
                repeat ($urandom_range(3, 6)) begin
                    send(t_op'($urandom_range(0, 7)), 16'($urandom));
                end
            end
            seq++;
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("[two_set_store_set_algebra_unit] OK");
        end else begin
            $display("[two_set_store_set_algebra_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #1500000;
        $display("[two_set_store_set_algebra_unit] ERROR");
        $finish;
    end

endmodule
